// ===== src/qdrp_pkg.sv =====
`timescale 1ns / 1ps

package qdrp_pkg;

    localparam int MAX_COLUMNS = 64;
    localparam int ROW_BITS    = 16;
    localparam int COL_BITS    = $clog2(MAX_COLUMNS);

    localparam logic [COL_BITS-1:0] COL_LAST = COL_BITS'(MAX_COLUMNS - 1);
    localparam logic [ROW_BITS-1:0] ROW_MAX  = {ROW_BITS{1'b1}};

    localparam logic [7:0] FIELD_SEP_RST  = 8'd59;
    localparam logic [7:0] RECORD_SEP_RST = 8'd10;
    localparam logic [7:0] QUOTE_RST      = 8'd124;

    typedef enum logic [1:0] {
        CFG_FIELD_SEP  = 2'd0,
        CFG_RECORD_SEP = 2'd1,
        CFG_QUOTE      = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        QS_OUT = 2'd0,
        QS_IN  = 2'd1,
        QS_ESC = 2'd2
    } t_qstate;

    typedef enum logic [1:0] {
        EV_CONTENT = 2'd0,
        EV_FIELD   = 2'd1,
        EV_LINE    = 2'd2,
        EV_STATUS  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_MISMATCH  = 3'd1,
        ST_NO_HEADER = 3'd2,
        ST_NO_DATA   = 3'd3,
        ST_TRAILING  = 3'd4,
        ST_OVERFLOW  = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0] field_sep;
        logic [7:0] record_sep;
        logic [7:0] quote;
    } t_cfg;

    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic [7:0] content;
        logic [5:0] column;
        logic [15:0] row;
        logic       header;
        logic       done;
        t_status    status;
    } t_event;

endpackage

// ===== src/qdrp_if.sv =====
`timescale 1ns / 1ps

interface qdrp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       final_byte;

    modport source (output valid, text_byte, final_byte, input ready);
    modport sink   (input valid, text_byte, final_byte, output ready);
endinterface

interface qdrp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [7:0]  content_byte;
    logic [5:0]  column_index;
    logic [15:0] row_index;
    logic        header_line;
    logic        reply_done;
    logic [2:0]  parse_status;

    modport source (output valid, event_kind, content_byte, column_index, row_index,
                    header_line, reply_done, parse_status, input ready);
    modport sink   (input valid, event_kind, content_byte, column_index, row_index,
                    header_line, reply_done, parse_status, output ready);
endinterface

interface qdrp_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/qdrp_cfg.sv =====
`timescale 1ns / 1ps

module qdrp_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    qdrp_cfg_if.sink      i_cfg,
    output qdrp_pkg::t_cfg o_cfg
);
    import qdrp_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.field_sep  <= FIELD_SEP_RST;
            r_cfg.record_sep <= RECORD_SEP_RST;
            r_cfg.quote      <= QUOTE_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_FIELD_SEP:  r_cfg.field_sep  <= i_cfg.data;
                CFG_RECORD_SEP: r_cfg.record_sep <= i_cfg.data;
                CFG_QUOTE:      r_cfg.quote      <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

// ===== src/qdrp_parser.sv =====
`timescale 1ns / 1ps

module qdrp_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  logic             i_final,
    input  qdrp_pkg::t_cfg   i_cfg,
    output qdrp_pkg::t_event o_event
);
    import qdrp_pkg::*;

    t_qstate               r_qstate, n_qstate;
    logic [COL_BITS-1:0]   r_col, n_col;
    logic [COL_BITS:0]     r_hdr_cols, n_hdr_cols;
    logic                  r_in_header, n_in_header;
    logic [ROW_BITS-1:0]   r_rows, n_rows;
    t_status               r_err, n_err;

    logic is_q, is_rs, is_fs, quoted_content, normal;
    logic [COL_BITS:0] count;

    assign is_q  = (i_byte == i_cfg.quote);
    assign is_rs = (i_byte == i_cfg.record_sep);
    assign is_fs = (i_byte == i_cfg.field_sep);
    assign quoted_content = ((r_qstate == QS_IN) && !is_q) || ((r_qstate == QS_ESC) && is_q);
    assign normal = (r_qstate == QS_OUT) || ((r_qstate == QS_ESC) && !is_q);
    assign count  = {1'b0, r_col} + 1'b1;

    // quote tracking
    always_comb begin
        n_qstate = r_qstate;
        if (r_err == ST_OK) begin
            unique case (r_qstate)
                QS_OUT:  n_qstate = is_q ? QS_IN : QS_OUT;
                QS_IN:   n_qstate = is_q ? QS_ESC : QS_IN;
                QS_ESC:  n_qstate = is_q ? QS_IN : QS_OUT;
                default: n_qstate = QS_OUT;
            endcase
        end
        if (i_final) begin
            n_qstate = QS_OUT;
        end
    end

    // events, counters and status
    always_comb begin
        n_col       = r_col;
        n_hdr_cols  = r_hdr_cols;
        n_in_header = r_in_header;
        n_rows      = r_rows;
        n_err       = r_err;
        o_event     = '0;
        o_event.kind    = EV_CONTENT;
        o_event.status  = ST_OK;
        o_event.content = i_byte;
        o_event.column  = 6'(r_col);
        o_event.row     = r_in_header ? 16'd0 : 16'(r_rows);
        o_event.header  = r_in_header;

        if (r_err == ST_OK) begin
            if (quoted_content) begin
                o_event.valid = 1'b1;
            end else if (normal) begin
                priority if (is_rs) begin
                    o_event.kind    = EV_LINE;
                    o_event.content = 8'd0;
                    if (r_in_header) begin
                        n_hdr_cols    = count;
                        n_in_header   = 1'b0;
                        n_col         = '0;
                        o_event.valid = 1'b1;
                    end else if (count != r_hdr_cols) begin
                        n_err = ST_MISMATCH;
                    end else if (r_rows == ROW_MAX) begin
                        n_err = ST_OVERFLOW;
                    end else begin
                        n_rows        = r_rows + 1'b1;
                        n_col         = '0;
                        o_event.valid = 1'b1;
                    end
                end else if (is_fs) begin
                    o_event.kind    = EV_FIELD;
                    o_event.content = 8'd0;
                    if (r_col == COL_LAST) begin
                        n_err = ST_OVERFLOW;
                    end else begin
                        n_col         = r_col + 1'b1;
                        o_event.valid = 1'b1;
                    end
                end else if (!is_q) begin
                    o_event.valid = 1'b1;
                end else begin
                    o_event.valid = 1'b0;
                end
            end
        end

        if (i_final) begin
            o_event.done = 1'b1;
            priority if (n_err != ST_OK) o_event.status = n_err;
            else if (n_in_header)        o_event.status = ST_NO_HEADER;
            else if (n_rows == '0)       o_event.status = ST_NO_DATA;
            else if (n_col != '0)        o_event.status = ST_TRAILING;
            else                         o_event.status = ST_OK;
            if (!o_event.valid) begin
                o_event.kind    = EV_STATUS;
                o_event.content = 8'd0;
                o_event.column  = 6'd0;
                o_event.row     = 16'd0;
                o_event.header  = 1'b0;
            end
            o_event.valid = 1'b1;
            n_col       = '0;
            n_hdr_cols  = '0;
            n_in_header = 1'b1;
            n_rows      = '0;
            n_err       = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qstate    <= QS_OUT;
            r_col       <= '0;
            r_hdr_cols  <= '0;
            r_in_header <= 1'b1;
            r_rows      <= '0;
            r_err       <= ST_OK;
        end else if (i_step) begin
            r_qstate    <= n_qstate;
            r_col       <= n_col;
            r_hdr_cols  <= n_hdr_cols;
            r_in_header <= n_in_header;
            r_rows      <= n_rows;
            r_err       <= n_err;
        end
    end

    a_err_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ST_OK) && !i_final |-> !o_event.valid)
        else $error("event produced after an error");

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (r_err != ST_OK) && !i_final |=> r_err == $past(r_err))
        else $error("error code changed before end of reply");

endmodule

// ===== src/quoted_delimited_record_parser.sv =====
`timescale 1ns / 1ps
// Path from input beat to result beat: input register, then result register.
// Throughput: one byte per cycle unless o_out.ready holds the result register; the
// per-byte compare and counter update sits between the two registers.
// Reset: synchronous active-low; parse state cleared, separators back to ';' LF '|'.
// Parse state also clears itself after the beat marked final_byte.

module quoted_delimited_record_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qdrp_in_if.sink    i_in,
    qdrp_cfg_if.sink   i_cfg,
    qdrp_out_if.source o_out
);
    import qdrp_pkg::*;

    t_cfg   cfg;
    t_event ev;

    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_final;
    logic       r_out_valid;
    t_event     r_out;
    logic       out_free, step;

    assign out_free   = !r_out_valid || o_out.ready;
    assign step       = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;

    qdrp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    qdrp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_byte),
        .i_final (r_final),
        .i_cfg   (cfg),
        .o_event (ev)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte  <= i_in.text_byte;
            r_final <= i_in.final_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step && ev.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && ev.valid) begin
            r_out <= ev;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.event_kind   = r_out.kind;
    assign o_out.content_byte = r_out.content;
    assign o_out.column_index = r_out.column;
    assign o_out.row_index    = r_out.row;
    assign o_out.header_line  = r_out.header;
    assign o_out.reply_done   = r_out.done;
    assign o_out.parse_status = r_out.status;

    a_status_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.kind == EV_STATUS) |->
            r_out.done && (r_out.column == 6'd0) && (r_out.row == 16'd0) && !r_out.header)
        else $error("status-only beat carries position data");

    a_status_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.status != ST_OK) |-> r_out.done)
        else $error("parse status without reply_done");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !out_free |=> r_in_valid && $stable(r_byte) && $stable(r_final))
        else $error("input stage lost a byte while stalled");

endmodule
